@@ src/mes_pkg.sv @@
// Shared types, codes and the smear hash of the mesh election scheduler.
`timescale 1ns / 1ps

package mes_pkg;

   localparam int NeighborsDefault = 16;
   localparam int MaxTriesDefault  = 4096;

   typedef enum logic [1:0] {
      OP_INSTALL = 2'd0,
      OP_UPDATE  = 2'd1,
      OP_TWO_HOP = 2'd2,
      OP_ELECT   = 2'd3
   } op_type;

   localparam logic [1:0] CSR_AWARE    = 2'd0;
   localparam logic [1:0] CSR_OWN_ID   = 2'd1;
   localparam logic [1:0] CSR_HOLDOFF  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AGE,
      ST_CAND,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic age;
      logic own_hash;
      logic scan_next;
      logic next_cand;
      logic win;
      logic give_up;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic elect_op;
      logic idx_last;
      logic limit;
      logic lose;
      logic out_free;
   } status_type;

   function automatic logic [15:0] smear16(input logic [15:0] v0);
      logic [31:0] v;
      v = {16'd0, v0};
      v = (v + (v << 12)) & 32'h0000_FFFF;
      v = v ^ (v >> 22);
      v = (v + (v << 4)) & 32'h0000_FFFF;
      v = v ^ (v >> 9);
      v = (v + (v << 10)) & 32'h0000_FFFF;
      v = v ^ (v >> 2);
      v = (v + (v << 7)) & 32'h0000_FFFF;
      v = v ^ (v >> 12);
      return v[15:0];
   endfunction

endpackage

@@ src/mesh_election_scheduler_core.sv @@
// Top level of the mesh election scheduler: controller and datapath.
//
//   channel  direction  handshake               beat contents
//   req_     in         req_valid / req_ready   one table command or election
//   rsp_     out        rsp_valid / rsp_ready   one result per request beat
//   csr_     in         csr_write_enable        register index and data
//
// Install and update pass from the accepting state to a finishing state that loads
// the output register. An election first walks all NEIGHBORS table entries to age them,
// then per candidate time computes its own hash and scans up to NEIGHBORS table entries,
// over at most MAX_TRIES candidates, and gives up at that limit or when the candidate
// time passes 16 bits; the table walk goes through one shared hash compare. Reset is
// synchronous and empties the table. A stalled rsp_ready holds the result; a new
// request beat is taken meanwhile and waits in the finishing state.
`timescale 1ns / 1ps

module mesh_election_scheduler_core #(
   parameter int NEIGHBORS = mes_pkg::NeighborsDefault,
   parameter int MAX_TRIES = mes_pkg::MaxTriesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [3:0]  req_entry_index,
   input  logic [15:0] req_node_id,
   input  logic [1:0]  req_hop_count,
   input  logic [15:0] req_next_xmt_time,
   input  logic [4:0]  req_next_xmt_mx,
   input  logic [2:0]  req_holdoff_exp,
   input  logic [31:0] req_current_slot,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_matched,
   output logic        rsp_elected,
   output logic        rsp_gave_up,
   output logic [15:0] rsp_own_next_time,
   output logic [12:0] rsp_own_next_mx
);

   mes_pkg::cmd_type    cmd;
   mes_pkg::status_type status;

   mes_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mes_datapath #(
      .NEIGHBORS (NEIGHBORS),
      .MAX_TRIES (MAX_TRIES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_opcode        (req_opcode),
      .req_entry_index   (req_entry_index),
      .req_node_id       (req_node_id),
      .req_hop_count     (req_hop_count),
      .req_next_xmt_time (req_next_xmt_time),
      .req_next_xmt_mx   (req_next_xmt_mx),
      .req_holdoff_exp   (req_holdoff_exp),
      .req_current_slot  (req_current_slot),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_matched       (rsp_matched),
      .rsp_elected       (rsp_elected),
      .rsp_gave_up       (rsp_gave_up),
      .rsp_own_next_time (rsp_own_next_time),
      .rsp_own_next_mx   (rsp_own_next_mx),
      .cmd               (cmd),
      .status            (status)
   );

endmodule

@@ src/mes_ctrl.sv @@
// Sequencing state machine of the mesh election scheduler.
`timescale 1ns / 1ps

module mes_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  mes_pkg::status_type status,
   output mes_pkg::cmd_type    cmd
);

   mes_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mes_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mes_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = status.elect_op ? mes_pkg::ST_AGE : mes_pkg::ST_EMIT;
            end
         end
         mes_pkg::ST_AGE: begin
            if (status.idx_last) state_in = mes_pkg::ST_CAND;
         end
         mes_pkg::ST_CAND: begin
            state_in = status.limit ? mes_pkg::ST_EMIT : mes_pkg::ST_SCAN;
         end
         mes_pkg::ST_SCAN: begin
            if (status.lose) state_in = mes_pkg::ST_CAND;
            else if (status.idx_last) state_in = mes_pkg::ST_EMIT;
         end
         mes_pkg::ST_EMIT: begin
            if (status.out_free) state_in = mes_pkg::ST_IDLE;
         end
         default: state_in = mes_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         mes_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         mes_pkg::ST_AGE: cmd.age = 1'b1;
         mes_pkg::ST_CAND: begin
            cmd.give_up  = status.limit;
            cmd.own_hash = !status.limit;
         end
         mes_pkg::ST_SCAN: begin
            cmd.next_cand = status.lose;
            cmd.win       = !status.lose && status.idx_last;
            cmd.scan_next = !status.lose && !status.idx_last;
         end
         mes_pkg::ST_EMIT: cmd.emit = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

@@ src/mes_datapath.sv @@
// Neighbour table, candidate counters, hash compare and result register.
`timescale 1ns / 1ps

module mes_datapath #(
   parameter int NEIGHBORS = mes_pkg::NeighborsDefault,
   parameter int MAX_TRIES = mes_pkg::MaxTriesDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_wdata,
   input  logic [1:0]          req_opcode,
   input  logic [3:0]          req_entry_index,
   input  logic [15:0]         req_node_id,
   input  logic [1:0]          req_hop_count,
   input  logic [15:0]         req_next_xmt_time,
   input  logic [4:0]          req_next_xmt_mx,
   input  logic [2:0]          req_holdoff_exp,
   input  logic [31:0]         req_current_slot,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic                rsp_matched,
   output logic                rsp_elected,
   output logic                rsp_gave_up,
   output logic [15:0]         rsp_own_next_time,
   output logic [12:0]         rsp_own_next_mx,
   input  mes_pkg::cmd_type    cmd,
   output mes_pkg::status_type status
);

   localparam int IW = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
   localparam int TW = $clog2(MAX_TRIES + 1);
   localparam logic [IW-1:0] LastIdx = IW'(NEIGHBORS - 1);

   logic        aware_ff;
   logic [15:0] own_id_ff;
   logic [2:0]  own_exp_ff;

   logic [NEIGHBORS-1:0] valid_ff;
   logic [15:0] id_ff       [NEIGHBORS];
   logic [1:0]  hops_ff     [NEIGHBORS];
   logic [15:0] time_ff     [NEIGHBORS];
   logic [2:0]  exp_ff      [NEIGHBORS];
   logic [31:0] stamp_ff    [NEIGHBORS];
   logic [16:0] earliest_ff [NEIGHBORS];

   logic [IW-1:0] idx_ff;
   logic [TW-1:0] tries_ff;
   logic [16:0]   cand_ff;
   logic [31:0]   slot_ff;
   logic [15:0]   hash_in_ff;
   logic          parity_ff;
   logic [15:0]   me1_ff, me2_ff;

   logic        res_matched_ff, res_elected_ff, res_gave_up_ff;
   logic [15:0] res_time_ff;
   logic [12:0] res_mx_ff;
   logic        out_valid_ff;

   logic          found;
   logic [IW-1:0] found_idx;
   logic [IW-1:0] ins_idx;
   logic          ins_ok;
   logic          upd_ok;
   logic [15:0]   upd_time;

   always_comb begin
      found     = 1'b0;
      found_idx = '0;
      for (int i = NEIGHBORS - 1; i >= 0; i--) begin
         if (valid_ff[i] && id_ff[i] == req_node_id) begin
            found     = 1'b1;
            found_idx = IW'(i);
         end
      end
   end

   assign ins_idx = IW'({3'd0, req_entry_index});
   assign ins_ok  = ({3'd0, req_entry_index} < 7'(NEIGHBORS));
   assign upd_ok  = found && ((req_opcode == mes_pkg::OP_UPDATE) ||
                    (req_opcode == mes_pkg::OP_TWO_HOP && aware_ff &&
                     hops_ff[found_idx] == 2'd2));
   assign upd_time = (aware_ff || req_opcode == mes_pkg::OP_TWO_HOP) ? req_next_xmt_time
                   : 16'(17'd1 + (17'(req_next_xmt_mx) << req_holdoff_exp));

   logic [31:0] elapsed;
   logic [15:0] aged_time;
   assign elapsed   = slot_ff - stamp_ff[idx_ff];
   assign aged_time = (32'(time_ff[idx_ff]) > elapsed)
                    ? 16'(32'(time_ff[idx_ff]) - elapsed) : 16'd0;

   logic [15:0] hash_in;
   assign hash_in = cand_ff[15:0] + slot_ff[15:0];

   logic [15:0] t_cur, n_id, n1, n2;
   logic        compete, tie_lose;
   assign t_cur = time_ff[idx_ff];
   assign n_id  = id_ff[idx_ff];
   assign n1    = mes_pkg::smear16(n_id ^ hash_in_ff);
   assign n2    = mes_pkg::smear16(n_id + hash_in_ff);
   assign compete = valid_ff[idx_ff] && ((t_cur == 16'd0) ||
                    (aware_ff && 17'(t_cur) == cand_ff) ||
                    (!aware_ff && cand_ff >= 17'(t_cur) &&
                     cand_ff <= 17'(t_cur) + (17'd1 << exp_ff[idx_ff])) ||
                    (earliest_ff[idx_ff] <= cand_ff));
   assign tie_lose = (!parity_ff && n_id > own_id_ff) || (parity_ff && n_id < own_id_ff);

   logic [15:0] win_x;
   assign win_x = 16'(cand_ff - 17'd1) >> own_exp_ff;

   assign status.elect_op = (req_opcode == mes_pkg::OP_ELECT);
   assign status.idx_last = (idx_ff == LastIdx);
   assign status.limit    = (tries_ff == TW'(MAX_TRIES)) || (cand_ff > 17'h0FFFF);
   assign status.lose     = compete && ((n1 > me1_ff) ||
                            (n1 == me1_ff && ((n2 > me2_ff) || (n2 == me2_ff && tie_lose))));
   assign status.out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         aware_ff   <= 1'b0;
         own_id_ff  <= 16'd0;
         own_exp_ff <= 3'd0;
      end else if (csr_write_enable) begin
         case (csr_index)
            mes_pkg::CSR_AWARE:   aware_ff   <= csr_wdata[0];
            mes_pkg::CSR_OWN_ID:  own_id_ff  <= csr_wdata;
            mes_pkg::CSR_HOLDOFF: own_exp_ff <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < NEIGHBORS; i++) begin
            time_ff[i]     <= 16'd0;
            exp_ff[i]      <= 3'd0;
            stamp_ff[i]    <= 32'd0;
            earliest_ff[i] <= 17'd0;
         end
      end else if (cmd.accept && req_opcode == mes_pkg::OP_INSTALL) begin
         if (ins_ok) begin
            valid_ff[ins_idx]    <= 1'b1;
            id_ff[ins_idx]       <= req_node_id;
            hops_ff[ins_idx]     <= req_hop_count;
            time_ff[ins_idx]     <= 16'd0;
            exp_ff[ins_idx]      <= 3'd0;
            stamp_ff[ins_idx]    <= 32'd0;
            earliest_ff[ins_idx] <= 17'd0;
         end
      end else if (cmd.accept && upd_ok) begin
         time_ff[found_idx]  <= upd_time;
         exp_ff[found_idx]   <= req_holdoff_exp;
         stamp_ff[found_idx] <= req_current_slot;
      end else if (cmd.age && valid_ff[idx_ff]) begin
         time_ff[idx_ff]     <= aged_time;
         stamp_ff[idx_ff]    <= slot_ff;
         earliest_ff[idx_ff] <= 17'(aged_time) + (17'd1 << (5'(exp_ff[idx_ff]) + 5'd4));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         slot_ff        <= req_current_slot;
         idx_ff         <= '0;
         tries_ff       <= '0;
         cand_ff        <= 17'd1 << (5'(own_exp_ff) + 5'd4);
         res_matched_ff <= !status.elect_op && upd_ok;
         res_elected_ff <= 1'b0;
         res_gave_up_ff <= 1'b0;
         res_time_ff    <= 16'd0;
         res_mx_ff      <= 13'd0;
      end
      if (cmd.age) idx_ff <= status.idx_last ? '0 : idx_ff + 1'b1;
      if (cmd.own_hash) begin
         idx_ff     <= '0;
         hash_in_ff <= hash_in;
         parity_ff  <= hash_in[0];
         me1_ff     <= mes_pkg::smear16(own_id_ff ^ hash_in);
         me2_ff     <= mes_pkg::smear16(own_id_ff + hash_in);
      end
      if (cmd.scan_next) idx_ff <= idx_ff + 1'b1;
      if (cmd.next_cand) begin
         tries_ff <= tries_ff + 1'b1;
         cand_ff  <= cand_ff + 17'd1;
      end
      if (cmd.win) begin
         res_elected_ff <= 1'b1;
         res_time_ff    <= cand_ff[15:0];
         res_mx_ff      <= (win_x > 16'd8191) ? 13'd8191 : win_x[12:0];
      end
      if (cmd.give_up) res_gave_up_ff <= 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_matched       <= res_matched_ff;
         rsp_elected       <= res_elected_ff;
         rsp_gave_up       <= res_gave_up_ff;
         rsp_own_next_time <= res_time_ff;
         rsp_own_next_mx   <= res_mx_ff;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

@@ src/mes_checker.sv @@
// Port-level checks of the mesh election scheduler and their binding.
`timescale 1ns / 1ps

module mes_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_matched,
   input logic        rsp_elected,
   input logic        rsp_gave_up,
   input logic [15:0] rsp_own_next_time
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_elected && rsp_gave_up))
      else $error("election both elected and gave up");

   a_match_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_matched |-> !rsp_elected && !rsp_gave_up)
      else $error("matched beat carries election flags");

   a_time_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_elected |-> rsp_own_next_time >= 16'd16)
      else $error("elected time below the hold-off base");

   a_time_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_elected |-> rsp_own_next_time == 16'd0)
      else $error("time given without an election");

endmodule

bind mesh_election_scheduler_core mes_checker u_mes_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_matched       (rsp_matched),
   .rsp_elected       (rsp_elected),
   .rsp_gave_up       (rsp_gave_up),
   .rsp_own_next_time (rsp_own_next_time)
);

@@ tb/tb_top.sv @@
// Self-checking testbench of the mesh election scheduler core.
`timescale 1ns / 1ps

module tb_top;

   localparam int TableSize = 16;
   localparam int TryLimit  = 4096;
   localparam int StallLimit = 400000;

   typedef struct {
      logic        matched;
      logic        elected;
      logic        gave_up;
      logic [15:0] own_time;
      logic [12:0] own_mx;
   } outcome_type;

   class ElectionScoreboard;
      logic             aware;
      logic [15:0]      own_id;
      logic [2:0]       own_exp;
      logic             valid_q[TableSize];
      logic [15:0]      id_q[TableSize];
      logic [1:0]       hops_q[TableSize];
      int unsigned      time_q[TableSize];
      logic [4:0]       mx_q[TableSize];
      logic [2:0]       exp_q[TableSize];
      int unsigned      stamp_q[TableSize];
      int unsigned      earliest_q[TableSize];
      logic             compete_q[TableSize];
      outcome_type      pending[$];
      int               errors;

      function new();
         aware = 0;
         own_id = 0;
         own_exp = 0;
         errors = 0;
         for (int i = 0; i < TableSize; i++) begin
            valid_q[i] = 0;
            id_q[i] = 0;
            hops_q[i] = 0;
            time_q[i] = 0;
            mx_q[i] = 0;
            exp_q[i] = 0;
            stamp_q[i] = 0;
            earliest_q[i] = 0;
            compete_q[i] = 0;
         end
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] data);
         if (idx == mes_pkg::CSR_AWARE) aware = data[0];
         else if (idx == mes_pkg::CSR_OWN_ID) own_id = data;
         else if (idx == mes_pkg::CSR_HOLDOFF) own_exp = data[2:0];
      endfunction

      function logic [15:0] mix16(logic [15:0] seed);
         int unsigned h;
         h = seed;
         h = (h + (h << 12)) & 32'hFFFF;
         h = h ^ (h >> 22);
         h = (h + (h << 4)) & 32'hFFFF;
         h = h ^ (h >> 9);
         h = (h + (h << 10)) & 32'hFFFF;
         h = h ^ (h >> 2);
         h = (h + (h << 7)) & 32'hFFFF;
         h = h ^ (h >> 12);
         return h[15:0];
      endfunction

      function int lookup(logic [15:0] id);
         for (int i = 0; i < TableSize; i++)
            if (valid_q[i] && id_q[i] == id) return i;
         return -1;
      endfunction

      function void mark(int unsigned cand);
         int unsigned t;
         for (int i = 0; i < TableSize; i++) begin
            t = time_q[i];
            if (!valid_q[i]) compete_q[i] = 0;
            else if (t == 0) compete_q[i] = 1;
            else if (aware && t == cand) compete_q[i] = 1;
            else if (!aware && cand >= t && cand <= t + (32'd1 << exp_q[i])) compete_q[i] = 1;
            else compete_q[i] = (earliest_q[i] <= cand);
         end
      endfunction

      function bit own_wins(int unsigned cand, int unsigned slot);
         int unsigned total;
         logic [15:0] a, me1, me2, n1, n2, nid;
         total = cand + slot;
         a = total[15:0];
         me1 = mix16(own_id ^ a);
         me2 = mix16(own_id + a);
         for (int i = 0; i < TableSize; i++) begin
            if (valid_q[i] && compete_q[i]) begin
               nid = id_q[i];
               n1 = mix16(nid ^ a);
               if (n1 > me1) return 0;
               if (n1 == me1) begin
                  n2 = mix16(nid + a);
                  if (n2 > me2) return 0;
                  if (n2 == me2) begin
                     if ((!total[0] && nid > own_id) || (total[0] && nid < own_id)) return 0;
                  end
               end
            end
         end
         return 1;
      endfunction

      function void note_request(mes_pkg::op_type op, logic [3:0] idx, logic [15:0] id,
                                 logic [1:0] hops, logic [15:0] ntime, logic [4:0] nmx,
                                 logic [2:0] nexp, logic [31:0] slot);
         outcome_type o;
         int e;
         int unsigned cand, x, el;
         o = '{0, 0, 0, 16'd0, 13'd0};
         case (op)
            mes_pkg::OP_INSTALL: begin
               valid_q[idx] = 1;
               id_q[idx] = id;
               hops_q[idx] = hops;
               time_q[idx] = 0;
               mx_q[idx] = 0;
               exp_q[idx] = 0;
               stamp_q[idx] = 0;
               earliest_q[idx] = 0;
               compete_q[idx] = 0;
            end
            mes_pkg::OP_UPDATE, mes_pkg::OP_TWO_HOP: begin
               e = lookup(id);
               if (e >= 0 && (op == mes_pkg::OP_UPDATE || (aware && hops_q[e] == 2))) begin
                  o.matched = 1;
                  time_q[e] = (aware || op == mes_pkg::OP_TWO_HOP) ? ntime
                              : 1 + (int'(nmx) << nexp);
                  mx_q[e] = nmx;
                  exp_q[e] = nexp;
                  stamp_q[e] = slot;
               end
            end
            default: begin
               for (int i = 0; i < TableSize; i++) begin
                  if (valid_q[i]) begin
                     el = slot - stamp_q[i];
                     stamp_q[i] = slot;
                     time_q[i] = (time_q[i] > el) ? time_q[i] - el : 0;
                     earliest_q[i] = time_q[i] + (32'd1 << (exp_q[i] + 4));
                  end
               end
               o.gave_up = 1;
               for (int k = 0; k < TryLimit; k++) begin
                  cand = (32'd1 << (own_exp + 4)) + k;
                  if (cand > 65535) break;
                  mark(cand);
                  if (own_wins(cand, slot)) begin
                     x = (cand - 1) >> own_exp;
                     o.gave_up = 0;
                     o.elected = 1;
                     o.own_time = cand[15:0];
                     o.own_mx = (x > 8191) ? 13'd8191 : x[12:0];
                     break;
                  end
               end
            end
         endcase
         pending = {pending, o};
      endfunction

      task report(string what);
         errors++;
         $display("mismatch at %0t: %s", $time, what);
      endtask

      task check_result(logic m, logic el, logic g, logic [15:0] t, logic [12:0] x);
         outcome_type o;
         if (pending.size() == 0) begin
            report("result beat with nothing expected");
            return;
         end
         o = pending.pop_front();
         if (m !== o.matched || el !== o.elected || g !== o.gave_up
             || t !== o.own_time || x !== o.own_mx)
            report($sformatf("got m%b e%b g%b t%0d x%0d, want m%b e%b g%b t%0d x%0d",
                             m, el, g, t, x, o.matched, o.elected, o.gave_up,
                             o.own_time, o.own_mx));
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_write_enable = 0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_opcode = '0;
   logic [3:0]  req_entry_index = '0;
   logic [15:0] req_node_id = '0;
   logic [1:0]  req_hop_count = '0;
   logic [15:0] req_next_xmt_time = '0;
   logic [4:0]  req_next_xmt_mx = '0;
   logic [2:0]  req_holdoff_exp = '0;
   logic [31:0] req_current_slot = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic        rsp_matched, rsp_elected, rsp_gave_up;
   logic [15:0] rsp_own_next_time;
   logic [12:0] rsp_own_next_mx;

   ElectionScoreboard board = new();
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          quiet_cycles = 0;
   logic [31:0] slot_now = 32'd100;
   logic [15:0] id_pool[8];

   mesh_election_scheduler_core DUT (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(rsp_matched, rsp_elected, rsp_gave_up,
                            rsp_own_next_time, rsp_own_next_mx);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_beat(mes_pkg::op_type op, logic [3:0] idx, logic [15:0] id,
                            logic [1:0] hops, logic [15:0] ntime, logic [4:0] nmx,
                            logic [2:0] nexp, logic [31:0] slot);
      int gap;
      req_valid <= 1;
      req_opcode <= op;
      req_entry_index <= idx;
      req_node_id <= id;
      req_hop_count <= hops;
      req_next_xmt_time <= ntime;
      req_next_xmt_mx <= nmx;
      req_holdoff_exp <= nexp;
      req_current_slot <= slot;
      do @(posedge clock); while (!req_ready);
      board.note_request(op, idx, id, hops, ntime, nmx, nexp, slot);
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(6, 1);
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_reg(logic [1:0] idx, logic [15:0] data);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_write_enable <= 0;
      board.write_reg(idx, data);
   endtask

   task automatic random_beat();
      int pick;
      logic [15:0] id;
      logic [1:0] hops;
      pick = $urandom_range(99);
      id = ($urandom_range(9) == 0) ? 16'($urandom) : id_pool[$urandom_range(7)];
      hops = ($urandom_range(19) == 0) ? 2'($urandom) : 2'($urandom_range(2, 1));
      slot_now = ($urandom_range(49) == 0) ? $urandom : slot_now + $urandom_range(40);
      if (pick < 20)
         send_beat(mes_pkg::OP_INSTALL, 4'($urandom), id, hops, 16'($urandom),
                   5'($urandom), 3'($urandom), $urandom);
      else if (pick < 45)
         send_beat(mes_pkg::OP_UPDATE, 4'($urandom), id, 2'($urandom),
                   16'($urandom_range(($urandom_range(3) == 0) ? 65535 : 300)),
                   5'($urandom), 3'($urandom), slot_now);
      else if (pick < 65)
         send_beat(mes_pkg::OP_TWO_HOP, 4'($urandom), id, 2'($urandom),
                   16'($urandom_range(($urandom_range(3) == 0) ? 65535 : 300)),
                   5'($urandom), 3'($urandom), slot_now);
      else
         send_beat(mes_pkg::OP_ELECT, 4'($urandom), 16'($urandom), 2'($urandom),
                   16'($urandom), 5'($urandom), 3'($urandom), slot_now);
   endtask

   initial begin
      for (int i = 0; i < 8; i++) id_pool[i] = 16'($urandom);
      id_pool[0] = 16'h0000;
      id_pool[1] = 16'hFFFF;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      send_beat(mes_pkg::OP_ELECT, 4'd0, 16'd0, 2'd1, 16'd0, 5'd0, 3'd0, 32'd0);
      send_beat(mes_pkg::OP_INSTALL, 4'd0, 16'h0000, 2'd1, 16'd0, 5'd0, 3'd0, 32'd0);
      send_beat(mes_pkg::OP_INSTALL, 4'd15, 16'hFFFF, 2'd2, 16'hFFFF, 5'd31, 3'd7,
                32'hFFFF_FFFF);
      send_beat(mes_pkg::OP_INSTALL, 4'd7, 16'hFFFF, 2'd1, 16'd0, 5'd0, 3'd0, 32'd0);
      send_beat(mes_pkg::OP_UPDATE, 4'd0, 16'hFFFF, 2'd0, 16'd5, 5'd31, 3'd7, 32'd10);
      send_beat(mes_pkg::OP_UPDATE, 4'd0, 16'h1234, 2'd3, 16'd5, 5'd3, 3'd1, 32'd10);
      send_beat(mes_pkg::OP_TWO_HOP, 4'd0, 16'hFFFF, 2'd0, 16'd40, 5'd1, 3'd0, 32'd10);
      send_beat(mes_pkg::OP_ELECT, 4'd0, 16'd0, 2'd0, 16'd0, 5'd0, 3'd0, 32'd12);
      send_beat(mes_pkg::OP_ELECT, 4'd0, 16'd0, 2'd0, 16'd0, 5'd0, 3'd0, 32'd5);
      drain();
      set_reg(mes_pkg::CSR_AWARE, 16'd1);
      set_reg(mes_pkg::CSR_OWN_ID, 16'hFFFF);
      set_reg(mes_pkg::CSR_HOLDOFF, 16'd7);
      send_beat(mes_pkg::OP_TWO_HOP, 4'd0, 16'hFFFF, 2'd0, 16'hFFFF, 5'd31, 3'd7, 32'd20);
      send_beat(mes_pkg::OP_TWO_HOP, 4'd0, 16'h0000, 2'd0, 16'd3, 5'd0, 3'd0, 32'd20);
      send_beat(mes_pkg::OP_UPDATE, 4'd0, 16'h0000, 2'd0, 16'd2048, 5'd0, 3'd0, 32'd20);
      send_beat(mes_pkg::OP_ELECT, 4'd0, 16'd0, 2'd0, 16'd0, 5'd0, 3'd0, 32'd20);
      send_beat(mes_pkg::OP_ELECT, 4'd0, 16'd0, 2'd0, 16'd0, 5'd0, 3'd0, 32'hFFFF_FFF0);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         set_reg(mes_pkg::CSR_AWARE, 16'(phase % 2));
         set_reg(mes_pkg::CSR_OWN_ID, (phase == 1) ? 16'hFFFF : (phase == 2) ? 16'h0000
                                                                : 16'($urandom));
         set_reg(mes_pkg::CSR_HOLDOFF, (phase == 1) ? 16'd7 : (phase == 2) ? 16'd0
                                                             : 16'($urandom_range(7)));
         send_idle_pct = (phase < 2) ? 27 : (phase < 4) ? 46 : 0;
         recv_idle_pct = (phase < 2) ? 46 : (phase < 4) ? 27 : 0;
         repeat (140) random_beat();
         drain();
      end

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
